### hdl/pse_pkg.sv
// Package for the postfix stack evaluator: character codes, error codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package pse_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int DATA_W          = 32;
    localparam int SYM_W           = 8;
    localparam int DIV_STEPS       = 32;
    localparam int DIV_CNT_W       = 6;

    localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_SLASH = 8'h2F;
    localparam logic [SYM_W-1:0] SYM_PCT   = 8'h25;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_OVERFLOW  = 3'd1,
        ERR_UNDERFLOW = 3'd2,
        ERR_DIVZERO   = 3'd3,
        ERR_MODZERO   = 3'd4,
        ERR_BADOP     = 3'd5
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP1,
        ST_EXEC,
        ST_DIVW,
        ST_PUSH,
        ST_FIN,
        ST_FOUT
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic load_digit;
        logic pop;
        logic capture_op2;
        logic exec;
        logic take_div;
        logic push;
        logic load_out;
    } pse_cmd_t;

    typedef struct packed {
        logic is_digit;
        logic last;
        logic div_go;
        logic div_done;
        logic out_free;
    } pse_status_t;

endpackage

### hdl/postfix_stack_evaluator_top.sv
// Postfix stack evaluator top level: one character per transfer, one result per expression.
// Per character: a digit is decoded and pushed; + - * pop two operands, execute and push;
// / % with a nonzero divisor also wait on the 32-step divider. A final character then adds
// a final pop and the output load. A result held by m_tready low stalls only the next
// final character. Reset (rst_n low, async): stack empty, no error pending, no result valid.
module postfix_stack_evaluator_top #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] value, [34:32] error, [39:35] zero
);

    pse_pkg::pse_cmd_t    cmd;
    pse_pkg::pse_status_t status;
    logic [pse_pkg::DATA_W-1:0] value;
    pse_pkg::err_t        error;

    pse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pse_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_symbol (s_tdata),
        .in_last   (s_tlast),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_value (value),
        .out_error (error)
    );

    assign m_tdata = {5'b0, error, value};

endmodule

### hdl/pse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/pse_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// Depends on pse_pkg.
module pse_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pse_pkg::DATA_W-1:0]  dividend,
    input  logic [pse_pkg::DATA_W-1:0]  divisor,
    output logic                        done,
    output logic [pse_pkg::DATA_W-1:0]  quot,
    output logic [pse_pkg::DATA_W-1:0]  remd
);

    localparam int W = pse_pkg::DATA_W;

    logic [pse_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          done_reg, done_next;
    logic [W-1:0]                  quo_reg, quo_next;
    logic [W-1:0]                  rem_reg, rem_next;
    logic [W-1:0]                  dvs_reg, dvs_next;
    logic                          neg_q_reg, neg_q_next;
    logic                          neg_r_reg, neg_r_next;
    logic [W:0]                    shifted;
    logic [W:0]                    diff;

    always_comb
    begin
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        shifted    = {rem_reg, quo_reg[W-1]};
        diff       = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            quo_next   = dividend[W-1] ? (W'(0) - dividend) : dividend;
            dvs_next   = divisor[W-1] ? (W'(0) - divisor) : divisor;
            rem_next   = '0;
            neg_q_next = dividend[W-1] ^ divisor[W-1];
            neg_r_next = dividend[W-1];
            cnt_next   = pse_pkg::DIV_CNT_W'(pse_pkg::DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - pse_pkg::DIV_CNT_W'(1);
            if (cnt_reg == pse_pkg::DIV_CNT_W'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    assign done = done_reg;
    assign quot = neg_q_reg ? (W'(0) - quo_reg) : quo_reg;
    assign remd = neg_r_reg ? (W'(0) - rem_reg) : rem_reg;

endmodule

### hdl/pse_datapath.sv
// Datapath: operand stack RAM, stack count, sticky error, ALU, divider, output register.
// Depends on pse_pkg, pse_ram and pse_div.
module pse_datapath #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pse_pkg::pse_cmd_t           cmd,
    output pse_pkg::pse_status_t        status,
    input  logic [pse_pkg::SYM_W-1:0]   in_symbol,
    input  logic                        in_last,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [pse_pkg::DATA_W-1:0]  out_value,
    output pse_pkg::err_t               out_error
);

    localparam int W  = pse_pkg::DATA_W;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [pse_pkg::SYM_W-1:0] sym_reg, sym_next;
    logic                      last_reg, last_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    pse_pkg::err_t             err_reg, err_next;
    logic [W-1:0]              op2_reg, op2_next;
    logic [W-1:0]              res_reg, res_next;
    logic                      pop_ok_reg, pop_ok_next;
    logic [W-1:0]              oval_reg, oval_next;
    pse_pkg::err_t             oerr_reg, oerr_next;
    logic                      ovalid_reg, ovalid_next;

    logic                      note_en;
    pse_pkg::err_t             note_code;
    logic [CW-1:0]             cnt_dec;
    logic [W-1:0]              popped;
    logic                      ram_we, ram_re;
    logic [AW-1:0]             ram_waddr, ram_raddr;
    logic [W-1:0]              ram_rdata;
    logic                      div_start, div_done;
    logic [W-1:0]              div_quot, div_remd;
    logic                      is_divmod;

    pse_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (res_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (popped),
        .divisor  (op2_reg),
        .done     (div_done),
        .quot     (div_quot),
        .remd     (div_remd)
    );

    assign cnt_dec   = cnt_reg - CW'(1);
    assign popped    = pop_ok_reg ? ram_rdata : '0;
    assign ram_raddr = cnt_dec[AW-1:0];
    assign ram_waddr = cnt_reg[AW-1:0];
    assign is_divmod = (sym_reg == pse_pkg::SYM_SLASH) || (sym_reg == pse_pkg::SYM_PCT);

    always_comb
    begin
        sym_next    = sym_reg;
        last_next   = last_reg;
        cnt_next    = cnt_reg;
        op2_next    = op2_reg;
        res_next    = res_reg;
        pop_ok_next = pop_ok_reg;
        oval_next   = oval_reg;
        oerr_next   = oerr_reg;
        ovalid_next = ovalid_reg && !out_ready;
        note_en     = 1'b0;
        note_code   = pse_pkg::ERR_NONE;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        div_start   = 1'b0;

        if (cmd.latch_in)
        begin
            sym_next  = in_symbol;
            last_next = in_last;
        end
        if (cmd.load_digit)
        begin
            res_next = {{(W - pse_pkg::SYM_W){1'b0}}, sym_reg - pse_pkg::SYM_ZERO};
        end
        if (cmd.capture_op2)
        begin
            op2_next = popped;
        end
        if (cmd.pop)
        begin
            if (cnt_reg == '0)
            begin
                note_en     = 1'b1;
                note_code   = pse_pkg::ERR_UNDERFLOW;
                pop_ok_next = 1'b0;
            end
            else
            begin
                cnt_next    = cnt_dec;
                ram_re      = 1'b1;
                pop_ok_next = 1'b1;
            end
        end
        if (cmd.exec)
        begin
            case (sym_reg)
                pse_pkg::SYM_PLUS:  res_next = popped + op2_reg;
                pse_pkg::SYM_MINUS: res_next = popped - op2_reg;
                pse_pkg::SYM_STAR:  res_next = W'(popped * op2_reg);
                pse_pkg::SYM_SLASH, pse_pkg::SYM_PCT:
                begin
                    res_next = '0;
                    if (op2_reg == '0)
                    begin
                        note_en   = 1'b1;
                        note_code = (sym_reg == pse_pkg::SYM_SLASH) ?
                                    pse_pkg::ERR_DIVZERO : pse_pkg::ERR_MODZERO;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
                default:
                begin
                    res_next  = '0;
                    note_en   = 1'b1;
                    note_code = pse_pkg::ERR_BADOP;
                end
            endcase
        end
        if (cmd.take_div)
        begin
            res_next = (sym_reg == pse_pkg::SYM_SLASH) ? div_quot : div_remd;
        end
        if (cmd.push)
        begin
            if (cnt_reg >= CW'(STACK_DEPTH))
            begin
                note_en   = 1'b1;
                note_code = pse_pkg::ERR_OVERFLOW;
            end
            else
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + CW'(1);
            end
        end

        err_next = (note_en && err_reg == pse_pkg::ERR_NONE) ? note_code : err_reg;

        if (cmd.load_out)
        begin
            oval_next   = popped;
            oerr_next   = err_reg;
            ovalid_next = 1'b1;
            cnt_next    = '0;
            err_next    = pse_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            err_reg    <= pse_pkg::ERR_NONE;
            ovalid_reg <= 1'b0;
            pop_ok_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            err_reg    <= err_next;
            ovalid_reg <= ovalid_next;
            pop_ok_reg <= pop_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg  <= sym_next;
        last_reg <= last_next;
        op2_reg  <= op2_next;
        res_reg  <= res_next;
        oval_reg <= oval_next;
        oerr_reg <= oerr_next;
    end

    always_comb
    begin
        status.is_digit = sym_reg inside {[pse_pkg::SYM_ZERO:pse_pkg::SYM_NINE]};
        status.last     = last_reg;
        status.div_go   = is_divmod && (op2_reg != '0);
        status.div_done = div_done;
        status.out_free = !ovalid_reg || out_ready;
    end

    assign out_valid = ovalid_reg;
    assign out_value = oval_reg;
    assign out_error = oerr_reg;

endmodule

### hdl/pse_ctrl.sv
// Controller state machine sequencing pops, operation, push and final result.
// Depends on pse_pkg.
module pse_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pse_pkg::pse_status_t  status,
    output pse_pkg::pse_cmd_t     cmd
);

    pse_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pse_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            pse_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = pse_pkg::ST_DECODE;
                end
            end
            pse_pkg::ST_DECODE:
            begin
                if (status.is_digit)
                begin
                    cmd.load_digit = 1'b1;
                    state_next     = pse_pkg::ST_PUSH;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = pse_pkg::ST_POP1;
                end
            end
            pse_pkg::ST_POP1:
            begin
                cmd.capture_op2 = 1'b1;
                cmd.pop         = 1'b1;
                state_next      = pse_pkg::ST_EXEC;
            end
            pse_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.div_go ? pse_pkg::ST_DIVW : pse_pkg::ST_PUSH;
            end
            pse_pkg::ST_DIVW:
            begin
                if (status.div_done)
                begin
                    cmd.take_div = 1'b1;
                    state_next   = pse_pkg::ST_PUSH;
                end
            end
            pse_pkg::ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = status.last ? pse_pkg::ST_FIN : pse_pkg::ST_IDLE;
            end
            pse_pkg::ST_FIN:
            begin
                cmd.pop    = 1'b1;
                state_next = pse_pkg::ST_FOUT;
            end
            pse_pkg::ST_FOUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = pse_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pse_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/pse_checker.sv
// Port-level checker for the postfix stack evaluator, bound to the top level.
// Depends on postfix_stack_evaluator_top.
module pse_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[34:32] <= 3'd5) && (m_tdata[39:35] == 5'd0))
        else $error("bad error code or padding");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable({s_tlast, s_tdata}))
        else $error("input transfer changed while waiting");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid in reset");

endmodule

bind postfix_stack_evaluator_top pse_checker u_pse_checker (.*);

### test/postfix_stack_evaluator_top_tb.sv
// Testbench for postfix_stack_evaluator_top: streams postfix expressions one character
// per transfer and checks every result against an in-bench stack machine predictor.
// Depends on pse_pkg and the RTL under hdl/.
module postfix_stack_evaluator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = pse_pkg::STACK_DEPTH_DEF;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 600;
    localparam int RANDOM_ITEMS = 2000;
    localparam logic [pse_pkg::SYM_W-1:0] OPS [5] = '{pse_pkg::SYM_PLUS, pse_pkg::SYM_MINUS,
                                                      pse_pkg::SYM_STAR, pse_pkg::SYM_SLASH,
                                                      pse_pkg::SYM_PCT};

    typedef struct packed {
        logic [pse_pkg::SYM_W-1:0] sym;
        logic                      fin;
        logic                      drain;
    } char_t;

    typedef struct {
        logic [pse_pkg::DATA_W-1:0] value;
        pse_pkg::err_t              error;
    } outcome_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] symbol
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // [31:0] value, [34:32] error, [39:35] zero

    char_t                     char_q [$];
    logic [pse_pkg::SYM_W-1:0] expr_buf [$];
    outcome_t                  due_results [$];

    logic [pse_pkg::DATA_W-1:0] calc_stack [DEPTH];
    int                         calc_depth = 0;
    pse_pkg::err_t              calc_err = pse_pkg::ERR_NONE;

    int          mismatches = 0;
    int          finals_sent = 0;
    int          results_seen = 0;
    int          src_gap = 0;
    int          src_calm = 0;
    int          snk_gap = 0;
    int          snk_calm = 0;
    int          hold_left = 0;
    int unsigned cycle_cnt = 0;
    char_t       cur_char;
    outcome_t    want;

    postfix_stack_evaluator_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- predictor ----------------
    function automatic void calc_note(pse_pkg::err_t e);
        if (calc_err == pse_pkg::ERR_NONE)
            calc_err = e;
    endfunction

    function automatic void calc_push(logic [pse_pkg::DATA_W-1:0] v);
        if (calc_depth >= DEPTH)
            calc_note(pse_pkg::ERR_OVERFLOW);
        else
        begin
            calc_stack[calc_depth] = v;
            calc_depth++;
        end
    endfunction

    function automatic logic [pse_pkg::DATA_W-1:0] calc_pop();
        if (calc_depth == 0)
        begin
            calc_note(pse_pkg::ERR_UNDERFLOW);
            return '0;
        end
        calc_depth--;
        return calc_stack[calc_depth];
    endfunction

    function automatic logic [pse_pkg::DATA_W-1:0] calc_apply(
        logic [pse_pkg::DATA_W-1:0] a,
        logic [pse_pkg::DATA_W-1:0] b,
        logic [pse_pkg::SYM_W-1:0]  sym);
        logic [pse_pkg::DATA_W-1:0] ma;
        logic [pse_pkg::DATA_W-1:0] mb;
        logic [pse_pkg::DATA_W-1:0] q;
        ma = a[pse_pkg::DATA_W-1] ? -a : a;
        mb = b[pse_pkg::DATA_W-1] ? -b : b;
        case (sym)
            pse_pkg::SYM_PLUS:  return a + b;
            pse_pkg::SYM_MINUS: return a - b;
            pse_pkg::SYM_STAR:  return a * b;
            pse_pkg::SYM_SLASH:
            begin
                if (b == '0)
                begin
                    calc_note(pse_pkg::ERR_DIVZERO);
                    return '0;
                end
                q = ma / mb;
                return (a[pse_pkg::DATA_W-1] != b[pse_pkg::DATA_W-1]) ? -q : q;
            end
            pse_pkg::SYM_PCT:
            begin
                if (b == '0)
                begin
                    calc_note(pse_pkg::ERR_MODZERO);
                    return '0;
                end
                q = ma % mb;
                return a[pse_pkg::DATA_W-1] ? -q : q;
            end
            default:
            begin
                calc_note(pse_pkg::ERR_BADOP);
                return '0;
            end
        endcase
    endfunction

    function automatic void eval_symbol(logic [pse_pkg::SYM_W-1:0] sym, logic fin);
        logic [pse_pkg::DATA_W-1:0] op1;
        logic [pse_pkg::DATA_W-1:0] op2;
        outcome_t                   res;
        if (sym >= pse_pkg::SYM_ZERO && sym <= pse_pkg::SYM_NINE)
            calc_push(32'(sym - pse_pkg::SYM_ZERO));
        else
        begin
            op2 = calc_pop();
            op1 = calc_pop();
            calc_push(calc_apply(op1, op2, sym));
        end
        if (fin)
        begin
            res.value = calc_pop();
            res.error = calc_err;
            due_results.push_back(res);
            calc_depth = 0;
            calc_err = pse_pkg::ERR_NONE;
        end
    endfunction

    // ---------------- stimulus builders ----------------
    function automatic logic [pse_pkg::SYM_W-1:0] digit(int d);
        return pse_pkg::SYM_ZERO + 8'(d);
    endfunction

    function automatic logic [pse_pkg::SYM_W-1:0] rand_op();
        return OPS[$urandom_range(0, 4)];
    endfunction

    function automatic void buf_text(string txt);
        for (int i = 0; i < txt.len(); i++)
            expr_buf.push_back(txt[i]);
    endfunction

    function automatic void flush_expr(bit drain);
        char_t c;
        for (int i = 0; i < expr_buf.size(); i++)
        begin
            c.sym = expr_buf[i];
            c.fin = (i == expr_buf.size() - 1);
            c.drain = drain && (i == 0);
            char_q.push_back(c);
        end
        expr_buf.delete();
    endfunction

    function automatic void gen_wellformed(int max_len);
        int d;
        int n;
        d = 0;
        n = $urandom_range(1, max_len);
        for (int i = 0; i < n; i++)
        begin
            if (d >= 2 && $urandom_range(0, 1) == 1)
            begin
                expr_buf.push_back(rand_op());
                d--;
            end
            else
            begin
                expr_buf.push_back(digit($urandom_range(0, 9)));
                d++;
            end
        end
        while (d > 1 && $urandom_range(0, 7) != 0)
        begin
            expr_buf.push_back(rand_op());
            d--;
        end
    endfunction

    // 8^10 * 2 wraps to the most negative value, then divided (/ or %) by -1 or a digit
    function automatic void gen_min_divide();
        expr_buf.push_back(digit(8));
        repeat (9)
        begin
            expr_buf.push_back(digit(8));
            expr_buf.push_back(pse_pkg::SYM_STAR);
        end
        buf_text("2*");
        if ($urandom_range(0, 2) != 0)
            buf_text("01-");
        else
            expr_buf.push_back(digit($urandom_range(0, 9)));
        expr_buf.push_back($urandom_range(0, 1) ? pse_pkg::SYM_SLASH : pse_pkg::SYM_PCT);
    endfunction

    function automatic void gen_mul_chain();
        expr_buf.push_back(digit($urandom_range(2, 9)));
        repeat ($urandom_range(5, 15))
        begin
            expr_buf.push_back(digit($urandom_range(2, 9)));
            expr_buf.push_back(pse_pkg::SYM_STAR);
        end
        if ($urandom_range(0, 1) == 1)
        begin
            expr_buf.push_back(digit($urandom_range(0, 9)));
            expr_buf.push_back(rand_op());
        end
    endfunction

    function automatic void gen_overflow();
        repeat ($urandom_range(DEPTH - 3, DEPTH + 7))
            expr_buf.push_back(digit($urandom_range(0, 9)));
        repeat ($urandom_range(0, 3))
            expr_buf.push_back(rand_op());
    endfunction

    function automatic int pick_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
            calm = $urandom_range(15, 50);
        return $urandom_range(0, 14);
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    // ---------------- driver ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                eval_symbol(s_tdata, s_tlast);
                if (s_tlast)
                    finals_sent++;
                src_gap = pick_gap(src_calm);
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (char_q.size() != 0 &&
                         !(char_q[0].drain && results_seen != finals_sent))
                begin
                    cur_char = char_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= cur_char.sym;
                    s_tlast <= cur_char.fin;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                    flag_mismatch($sformatf("unexpected result value=%0d error=%0d",
                                            $signed(m_tdata[31:0]), m_tdata[34:32]));
                else
                begin
                    want = due_results.pop_front();
                    if (m_tdata[31:0] !== want.value)
                        flag_mismatch($sformatf("value got %0d want %0d",
                                                $signed(m_tdata[31:0]), $signed(want.value)));
                    if (m_tdata[34:32] !== want.error)
                        flag_mismatch($sformatf("error got %0d want %0d",
                                                m_tdata[34:32], want.error));
                end
                results_seen <= results_seen + 1;
                snk_gap = pick_gap(snk_calm);
                // long back-pressure so the block fills and stalls its input
                if (results_seen == 30 || results_seen == 150)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (snk_gap > 0)
            begin
                snk_gap--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------- sequence ----------------
    initial
    begin
        int n_directed;
        int pick;
        bit first_random;
        bit mid_done;

        buf_text("9");
        flush_expr(1'b0);
        buf_text("+");
        flush_expr(1'b0);
        buf_text("50/");
        flush_expr(1'b0);
        buf_text("50%");
        flush_expr(1'b0);
        buf_text("12");
        expr_buf.push_back(8'hFF);
        flush_expr(1'b0);
        expr_buf.push_back(8'h00);
        buf_text("7");
        flush_expr(1'b0);
        buf_text("29-3/29-3%*");
        flush_expr(1'b0);
        buf_text("999");
        flush_expr(1'b0);

        n_directed = char_q.size();
        first_random = 1'b1;
        mid_done = 1'b0;
        while (char_q.size() < n_directed + RANDOM_ITEMS)
        begin
            if (!mid_done && char_q.size() >= n_directed + RANDOM_ITEMS / 2)
            begin
                gen_overflow();
                flush_expr(1'b1);
                mid_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 65)
                gen_wellformed(12);
            else if (pick < 75)
            begin
                repeat ($urandom_range(1, 6))
                    expr_buf.push_back(8'($urandom_range(0, 255)));
            end
            else if (pick < 85)
            begin
                gen_wellformed(10);
                expr_buf[$urandom_range(0, expr_buf.size() - 1)] = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 3) == 0)
                    expr_buf.push_front(rand_op());
            end
            else if (pick < 92)
                gen_min_divide();
            else if (pick < 98)
                gen_mul_chain();
            else
                gen_overflow();
            flush_expr(first_random);
            first_random = 1'b0;
        end

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (char_q.size() != 0 || s_tvalid || results_seen != finals_sent);
        repeat (60) @(negedge clk);
        if (due_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", due_results.size()));

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
hdl/pse_pkg.sv
hdl/pse_ram.sv
hdl/pse_div.sv
hdl/pse_datapath.sv
hdl/pse_ctrl.sv
hdl/postfix_stack_evaluator_top.sv
hdl/pse_checker.sv
test/postfix_stack_evaluator_top_tb.sv
